>>> hw/rtl/bfa_pkg.sv
// Shared constants, types and state codes of the bitmap frame allocator.
package bfa_pkg;

  localparam int ADDR_W     = 48;
  localparam int CNT_W      = 15;
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_FRAMES = 16384;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int FIDX_W     = $clog2(MAX_FRAMES);
  localparam int OFF_W      = ADDR_W - PAGE_SHIFT;
  localparam int STEP_W     = ADDR_W + 1 - PAGE_SHIFT;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(1);

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RESERVE = 1'b1;
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_FAIL   = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
    word_t              data;
  } wr_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              status;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ASCAN,
    ST_AADDR,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_R4,
    ST_RMARK,
    ST_DONE
  } ctrl_state_t;

endpackage

>>> hw/rtl/bfa_map.sv
// Used-bit map: synchronous memory with registered read data and per-word valid bits.
module bfa_map (
  input  logic             clk,
  input  logic             rst_n,
  input  bfa_pkg::rd_req_t rd_req,
  input  bfa_pkg::wr_req_t wr_req,
  output bfa_pkg::word_t   rd_data
);

  bfa_pkg::word_t                   map_mem [bfa_pkg::MAP_WORDS];
  logic [bfa_pkg::MAP_WORDS-1:0]    vld_r;
  bfa_pkg::word_t                   q_r;
  logic                             q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      map_mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      q_r <= map_mem[rd_req.addr];
    end
  end

  // A word never written reads as clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        vld_r[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        q_vld_r <= vld_r[rd_req.addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

>>> hw/rtl/bfa_ctrl.sv
// Request sequencer: word scan for allocate, range walk for reserve.
module bfa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [bfa_pkg::ADDR_W-1:0]    range_start,
  input  logic [bfa_pkg::ADDR_W-1:0]    range_end,
  input  logic [bfa_pkg::ADDR_W-1:0]    base_addr,
  input  logic [bfa_pkg::CNT_W-1:0]     frame_cnt,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bfa_pkg::result_t              res,
  output bfa_pkg::rd_req_t              rd_req,
  output bfa_pkg::wr_req_t              wr_req,
  input  bfa_pkg::word_t                rd_data
);

  localparam logic [bfa_pkg::BIT_W-1:0] TOP_BIT = bfa_pkg::BIT_W'(bfa_pkg::WORD_BITS - 1);

  function automatic logic [bfa_pkg::BIT_W-1:0] enc_onehot(input bfa_pkg::word_t oh);
    logic [bfa_pkg::BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
      if (oh[i]) begin
        idx = idx | bfa_pkg::BIT_W'(i);
      end
    end
    return idx;
  endfunction

  bfa_pkg::ctrl_state_t state_r, state_nxt;

  logic [bfa_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bfa_pkg::ADDR_W-1:0]  start_r, start_nxt;
  logic [bfa_pkg::ADDR_W-1:0]  end_r, end_nxt;
  logic [bfa_pkg::OFF_W-1:0]   first_r, first_nxt;
  logic [bfa_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic                        ok_r, ok_nxt;
  logic [bfa_pkg::CNT_W-1:0]   room_r, room_nxt;
  logic [bfa_pkg::WORD_AW-1:0] firstw_r, firstw_nxt;
  logic [bfa_pkg::BIT_W-1:0]   firstb_r, firstb_nxt;
  logic [bfa_pkg::WORD_AW-1:0] lastw_r, lastw_nxt;
  logic [bfa_pkg::BIT_W-1:0]   lastb_r, lastb_nxt;
  logic [bfa_pkg::WORD_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic                        iss_done_r, iss_done_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [bfa_pkg::WORD_AW-1:0] chk_word_r, chk_word_nxt;
  logic [bfa_pkg::FIDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  bfa_pkg::result_t            res_r, res_nxt;

  logic [bfa_pkg::CNT_W-1:0]   act_cnt;
  logic [bfa_pkg::CNT_W-1:0]   last_idx;
  logic [bfa_pkg::CNT_W-1:0]   stop_idx;
  logic [bfa_pkg::CNT_W-1:0]   stop_m1;
  logic [bfa_pkg::ADDR_W-1:0]  diff;
  logic [bfa_pkg::ADDR_W-1:0]  off;
  logic [bfa_pkg::ADDR_W:0]    rounded;
  logic                        issue;
  bfa_pkg::word_t              vmask;
  bfa_pkg::word_t              free_bits;
  bfa_pkg::word_t              iso;
  logic [bfa_pkg::BIT_W-1:0]   lo_bit;
  logic [bfa_pkg::BIT_W-1:0]   hi_bit;
  bfa_pkg::word_t              rmask;

  assign act_cnt  = (frame_cnt > bfa_pkg::CNT_W'(bfa_pkg::MAX_FRAMES)) ?
                    bfa_pkg::CNT_W'(bfa_pkg::MAX_FRAMES) : frame_cnt;
  assign last_idx = act_cnt - bfa_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfa_pkg::ST_IDLE;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    first_r    <= first_nxt;
    steps_r    <= steps_nxt;
    ok_r       <= ok_nxt;
    room_r     <= room_nxt;
    firstw_r   <= firstw_nxt;
    firstb_r   <= firstb_nxt;
    lastw_r    <= lastw_nxt;
    lastb_r    <= lastb_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    iss_done_r <= iss_done_nxt;
    chk_word_r <= chk_word_nxt;
    hit_idx_r  <= hit_idx_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    first_nxt    = first_r;
    steps_nxt    = steps_r;
    ok_nxt       = ok_r;
    room_nxt     = room_r;
    firstw_nxt   = firstw_r;
    firstb_nxt   = firstb_r;
    lastw_nxt    = lastw_r;
    lastb_nxt    = lastb_r;
    rd_ptr_nxt   = rd_ptr_r;
    iss_done_nxt = iss_done_r;
    chk_vld_nxt  = 1'b0;
    chk_word_nxt = chk_word_r;
    hit_idx_nxt  = hit_idx_r;
    res_nxt      = res_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    rd_req       = '0;
    wr_req       = '0;

    diff      = end_r - start_r;
    off       = start_r - base_addr;
    rounded   = {1'b0, diff} + (bfa_pkg::ADDR_W + 1)'(bfa_pkg::PAGE_BYTES - 1);
    stop_idx  = (steps_r < bfa_pkg::STEP_W'(room_r)) ?
                first_r[bfa_pkg::CNT_W-1:0] + steps_r[bfa_pkg::CNT_W-1:0] : cnt_r;
    stop_m1   = stop_idx - bfa_pkg::CNT_W'(1);

    // Scan and walk share the read pipeline: issue one word a cycle, check it the next.
    issue     = ((state_r == bfa_pkg::ST_ASCAN) || (state_r == bfa_pkg::ST_RMARK)) &&
                !iss_done_r;
    vmask     = (chk_word_r == lastw_r) ? ({bfa_pkg::WORD_BITS{1'b1}} >> (TOP_BIT - lastb_r))
                                        : {bfa_pkg::WORD_BITS{1'b1}};
    free_bits = ~rd_data & vmask;
    iso       = free_bits & (~free_bits + bfa_pkg::WORD_BITS'(1));
    lo_bit    = (chk_word_r == firstw_r) ? firstb_r : '0;
    hi_bit    = (chk_word_r == lastw_r) ? lastb_r : TOP_BIT;
    rmask     = ({bfa_pkg::WORD_BITS{1'b1}} << lo_bit) &
                ({bfa_pkg::WORD_BITS{1'b1}} >> (TOP_BIT - hi_bit));

    if (issue) begin
      rd_req.en    = 1'b1;
      rd_req.addr  = rd_ptr_r;
      chk_vld_nxt  = 1'b1;
      chk_word_nxt = rd_ptr_r;
      if (rd_ptr_r == lastw_r) begin
        iss_done_nxt = 1'b1;
      end else begin
        rd_ptr_nxt = rd_ptr_r + bfa_pkg::WORD_AW'(1);
      end
    end

    unique case (state_r)
      bfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt        = act_cnt;
          start_nxt      = range_start;
          end_nxt        = range_end;
          res_nxt.addr   = '0;
          res_nxt.status = bfa_pkg::STAT_OK;
          rd_ptr_nxt     = '0;
          iss_done_nxt   = 1'b0;
          firstw_nxt     = '0;
          firstb_nxt     = '0;
          lastw_nxt      = last_idx[bfa_pkg::BIT_W +: bfa_pkg::WORD_AW];
          lastb_nxt      = last_idx[bfa_pkg::BIT_W-1:0];
          if (act_cnt == '0) begin
            res_nxt.status = bfa_pkg::STAT_FAIL;
            state_nxt      = bfa_pkg::ST_DONE;
          end else if (req_type == bfa_pkg::REQ_ALLOC) begin
            state_nxt = bfa_pkg::ST_ASCAN;
          end else begin
            state_nxt = bfa_pkg::ST_R1;
          end
        end
      end
      bfa_pkg::ST_ASCAN: begin
        if (chk_vld_r) begin
          if (free_bits != '0) begin
            wr_req.en   = 1'b1;
            wr_req.addr = chk_word_r;
            wr_req.data = rd_data | iso;
            hit_idx_nxt = {chk_word_r, enc_onehot(iso)};
            state_nxt   = bfa_pkg::ST_AADDR;
          end else if (chk_word_r == lastw_r) begin
            res_nxt.status = bfa_pkg::STAT_FAIL;
            state_nxt      = bfa_pkg::ST_DONE;
          end
        end
      end
      bfa_pkg::ST_AADDR: begin
        res_nxt.addr = base_addr +
                       (bfa_pkg::ADDR_W'(hit_idx_r) << bfa_pkg::PAGE_SHIFT);
        state_nxt    = bfa_pkg::ST_DONE;
      end
      bfa_pkg::ST_R1: begin
        if (start_r < base_addr) begin
          start_nxt = base_addr;
        end
        state_nxt = bfa_pkg::ST_R2;
      end
      bfa_pkg::ST_R2: begin
        ok_nxt    = end_r > start_r;
        first_nxt = off[bfa_pkg::ADDR_W-1:bfa_pkg::PAGE_SHIFT];
        steps_nxt = rounded[bfa_pkg::ADDR_W:bfa_pkg::PAGE_SHIFT];
        state_nxt = bfa_pkg::ST_R3;
      end
      bfa_pkg::ST_R3: begin
        if (ok_r && (first_r < bfa_pkg::OFF_W'(cnt_r))) begin
          room_nxt  = cnt_r - first_r[bfa_pkg::CNT_W-1:0];
          state_nxt = bfa_pkg::ST_R4;
        end else begin
          state_nxt = bfa_pkg::ST_DONE;
        end
      end
      bfa_pkg::ST_R4: begin
        firstw_nxt   = first_r[bfa_pkg::BIT_W +: bfa_pkg::WORD_AW];
        firstb_nxt   = first_r[bfa_pkg::BIT_W-1:0];
        lastw_nxt    = stop_m1[bfa_pkg::BIT_W +: bfa_pkg::WORD_AW];
        lastb_nxt    = stop_m1[bfa_pkg::BIT_W-1:0];
        rd_ptr_nxt   = first_r[bfa_pkg::BIT_W +: bfa_pkg::WORD_AW];
        iss_done_nxt = 1'b0;
        state_nxt    = bfa_pkg::ST_RMARK;
      end
      bfa_pkg::ST_RMARK: begin
        // Write word w back while word w+1 is being read: never the same entry.
        if (chk_vld_r) begin
          wr_req.en   = 1'b1;
          wr_req.addr = chk_word_r;
          wr_req.data = rd_data | rmask;
          if (chk_word_r == lastw_r) begin
            state_nxt = bfa_pkg::ST_DONE;
          end
        end
      end
      bfa_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

>>> hw/rtl/bitmap_frame_allocator_core.sv
// Top level of the bitmap page frame allocator: config registers, map, sequencer, output stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tdata: range_start, range_end; tuser: req_type
//  out_    | master    | out_tvalid/tready  | tdata: frame_address; tuser: status
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (base_address, frame_count)
//
// One request is in work at a time. Allocate scans the map words in order up to the first
// free bit (at most ceil(min(frame_count, 16384) / 64) words): the scan reads one map word
// per cycle from the two-port (one read, one write) synchronous map memory. Reserve walks the
// map words that its range covers with one read-modify-write per word, pipelined. A request
// with frame_count zero goes straight to the result with status fail, without reading the map.
// Reset clears the map through per-word valid bits at once: no clearing pass is needed.
// A finished result waits in the output register, so the next request is taken while it stalls.
module bitmap_frame_allocator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata fields, lowest bit up: range_start[47:0], range_end[95:48]
  input  logic [2*bfa_pkg::ADDR_W-1:0]       in_tdata,
  // in_tuser fields: req_type[0]
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata fields, lowest bit up: frame_address[47:0]
  output logic [bfa_pkg::ADDR_W-1:0]         out_tdata,
  // out_tuser fields: status[0]
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfa_pkg::ADDR_W-1:0]         cfg_data
);

  logic [bfa_pkg::ADDR_W-1:0] base_r;
  logic [bfa_pkg::CNT_W-1:0]  count_r;

  logic                       out_valid_r, out_valid_nxt;
  bfa_pkg::result_t           out_res_r, out_res_nxt;

  logic                       res_valid;
  logic                       res_ready;
  bfa_pkg::result_t           res;
  bfa_pkg::rd_req_t           rd_req;
  bfa_pkg::wr_req_t           wr_req;
  bfa_pkg::word_t             rd_data;

  // Configuration is always accepted; unknown indexes drop the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bfa_pkg::REG_BASE:  base_r  <= cfg_data;
        bfa_pkg::REG_COUNT: count_r <= cfg_data[bfa_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bfa_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  bfa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .req_type    (in_tuser),
    .range_start (in_tdata[bfa_pkg::ADDR_W-1:0]),
    .range_end   (in_tdata[2*bfa_pkg::ADDR_W-1:bfa_pkg::ADDR_W]),
    .base_addr   (base_r),
    .frame_cnt   (count_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .rd_req      (rd_req),
    .wr_req      (wr_req),
    .rd_data     (rd_data)
  );

  // Output register: load when empty or when the held transaction leaves this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.addr;
  assign out_tuser  = out_res_r.status;

endmodule

>>> test/tb_bitmap_frame_allocator_core.sv
// Self-checking testbench of the bitmap frame allocator core: directed and random traffic.
`timescale 1ns / 100ps

module tb_bitmap_frame_allocator_core;
  import bfa_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // cycles with no transaction before giving up
  localparam int DRAIN_WAIT = 300;    // beyond the longest scan of a full map
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] TOP_PAGE = ALL_ONES & ~ADDR_W'(PAGE_BYTES - 1);
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [2*ADDR_W-1:0]    in_tdata = '0;
  logic                   in_tuser = REQ_ALLOC;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [ADDR_W-1:0]      out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_BASE;
  logic [ADDR_W-1:0]      cfg_data = '0;

  // Allocator image: used bit per frame and the two registers as last written.
  bit                     frame_used [MAX_FRAMES];
  logic [ADDR_W-1:0]      map_base = '0;
  logic [CNT_W-1:0]       map_count = '0;

  result_t                grant_queue [$];   // frame grants still owed by the block
  result_t                want;
  int                     sender_gap_pct = 27;
  int                     sink_stall_pct = 59;
  int                     mismatches = 0;
  int                     idle_cycles = 0;
  int                     alloc_granted = 0;
  int                     alloc_refused = 0;
  int                     reserves_sent = 0;
  int                     reg_writes = 0;

  bitmap_frame_allocator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Work out the grant for one request and update the map image to match.
  function automatic result_t predict_grant(input logic rtype,
                                            input logic [ADDR_W-1:0] rs,
                                            input logic [ADDR_W-1:0] re);
    result_t         res;
    longint unsigned active;
    longint unsigned base_a;
    longint unsigned start_a;
    longint unsigned end_a;
    longint unsigned first_f;
    longint unsigned steps;
    longint unsigned stop_f;
    longint unsigned i;
    res.addr   = '0;
    res.status = STAT_OK;
    base_a = map_base;
    active = (map_count > MAX_FRAMES) ? MAX_FRAMES : map_count;  // clamp oversized count
    if (active == 0) begin
      // not set up: refuse both kinds, touch nothing
      res.status = STAT_FAIL;
      if (rtype == REQ_ALLOC) alloc_refused++;
    end else if (rtype == REQ_ALLOC) begin
      res.status = STAT_FAIL;
      for (i = 0; i < active; i++) begin
        if (!frame_used[i]) begin
          frame_used[i] = 1'b1;
          res.addr   = ADDR_W'(base_a + i * PAGE_BYTES);  // wraps modulo the address space
          res.status = STAT_OK;
          break;
        end
      end
      if (res.status == STAT_OK) alloc_granted++;
      else alloc_refused++;
    end else begin
      start_a = rs;
      end_a   = re;
      if (start_a < base_a) start_a = base_a;
      // empty or reversed ranges reserve nothing but still succeed
      if (end_a > start_a) begin
        first_f = (start_a - base_a) / PAGE_BYTES;
        steps   = (end_a - start_a + PAGE_BYTES - 1) / PAGE_BYTES;
        if (first_f < active) begin
          stop_f = (steps < active - first_f) ? first_f + steps : active;
          for (i = first_f; i < stop_f; i++) frame_used[i] = 1'b1;
        end
      end
    end
    if (rtype == REQ_RESERVE) reserves_sent++;
    return res;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // Present one request; the grant is predicted at the edge the transaction completes.
  // Valid stays high afterwards so back-to-back requests need no second assignment.
  task automatic send_request(input logic rtype, input logic [ADDR_W-1:0] rs,
                              input logic [ADDR_W-1:0] re);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {re, rs};
    in_tuser  <= rtype;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    grant_queue.push_back(predict_grant(rtype, rs, re));
  endtask

  // Write one register with the input already idle; valid is dropped by the next
  // request, so consecutive writes keep it high without a second assignment in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BASE) map_base = value;
    else if (idx == REG_COUNT) map_count = value[CNT_W-1:0];
    reg_writes++;
  endtask

  // Hold the input idle for at least one edge and until every owed grant has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (grant_queue.size() != 0);
  endtask

  // After reset the count is zero: every request is refused, writes to
  // unknown indexes must leave the registers alone.
  task automatic test_not_set_up();
    write_reg(REG_SPARE_LO, rand48());
    write_reg(REG_SPARE_HI, ALL_ONES);
    send_request(REQ_ALLOC, rand48(), rand48());
    send_request(REQ_RESERVE, '0, ALL_ONES);
    wait_drained();
  endtask

  // Four-frame map: clamp below base, empty, reversed and overhanging ranges, map full.
  task automatic test_small_map();
    logic [ADDR_W-1:0] b;
    b = ADDR_W'(48'h0000_0400_0000);
    write_reg(REG_BASE, b);
    write_reg(REG_COUNT, ADDR_W'(4));
    send_request(REQ_RESERVE, '0, b + ADDR_W'(PAGE_BYTES));
    send_request(REQ_RESERVE, b + ADDR_W'(2 * PAGE_BYTES), b + ADDR_W'(2 * PAGE_BYTES));
    send_request(REQ_RESERVE, b + ADDR_W'(3 * PAGE_BYTES), b + ADDR_W'(PAGE_BYTES));
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_RESERVE, b + ADDR_W'(2 * PAGE_BYTES + 5), ALL_ONES);
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_RESERVE, b + ADDR_W'(10 * PAGE_BYTES), ALL_ONES);
    wait_drained();
  endtask

  // Base on the top page with an oversized count: grant addresses wrap to zero.
  task automatic test_address_wrap();
    write_reg(REG_BASE, TOP_PAGE);
    write_reg(REG_COUNT, ADDR_W'(32767));
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_ALLOC, ALL_ONES, ALL_ONES);
    send_request(REQ_RESERVE, ALL_ONES, ALL_ONES);
    wait_drained();
  endtask

  // Base zero, full-size map, last frame and beyond, then one frame, then none.
  task automatic test_map_extremes();
    write_reg(REG_BASE, '0);
    write_reg(REG_COUNT, {33'h1_FFFF_FFFF, CNT_W'(MAX_FRAMES)});  // junk above the count
    send_request(REQ_RESERVE, '0, '0);
    send_request(REQ_RESERVE, ADDR_W'((MAX_FRAMES - 1) * PAGE_BYTES),
                 ADDR_W'(MAX_FRAMES * PAGE_BYTES));
    send_request(REQ_RESERVE, ADDR_W'(MAX_FRAMES * PAGE_BYTES), ALL_ONES);
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_ALLOC, '0, '0);
    wait_drained();
    write_reg(REG_COUNT, ADDR_W'(1));
    send_request(REQ_ALLOC, '0, '0);
    wait_drained();
    write_reg(REG_COUNT, '0);
    send_request(REQ_RESERVE, '0, ALL_ONES);
    wait_drained();
  endtask

  // Blocks of random requests, each under a fresh register setting. Reserves
  // mostly target short ranges inside the map so allocations keep finding
  // gaps; a share are noise, empty, reversed or start below the base.
  task automatic test_random_traffic(input int item_total);
    int                sent;
    int                block_len;
    int                pick;
    int                span;
    int                len;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] junk;
    logic [ADDR_W-1:0] rs;
    logic [ADDR_W-1:0] re;
    sent = 0;
    while (sent < item_total) begin
      wait_drained();
      pick = $urandom_range(99);
      if (pick < 10) write_reg(REG_BASE, '0);
      else if (pick < 25)
        write_reg(REG_BASE, TOP_PAGE - ADDR_W'($urandom_range(64) * PAGE_BYTES));
      else if (pick < 40) write_reg(REG_BASE, rand48());
      else write_reg(REG_BASE, rand48() & ~ADDR_W'(PAGE_BYTES - 1));
      pick = $urandom_range(99);
      if (pick < 5) cnt = '0;
      else if (pick < 12) cnt = CNT_W'(MAX_FRAMES);
      else if (pick < 20) cnt = CNT_W'($urandom_range(32767, MAX_FRAMES + 1));
      else if (pick < 60) cnt = CNT_W'($urandom_range(256, 1));
      else cnt = CNT_W'($urandom_range(4096, 257));
      // upper data bits carry junk half the time
      junk = $urandom_range(1) ? rand48() : '0;
      write_reg(REG_COUNT, {junk[ADDR_W-1:CNT_W], cnt});
      span = (map_count == 0) ? 64 : ((map_count > MAX_FRAMES) ? MAX_FRAMES : map_count);
      block_len = $urandom_range(60, 15);
      repeat (block_len) begin
        if ($urandom_range(99) < 55) begin
          send_request(REQ_ALLOC, rand48(), rand48());
        end else begin
          rs = map_base + ADDR_W'($urandom_range(span + 8, 0) * PAGE_BYTES);
          if ($urandom_range(1)) rs = rs + ADDR_W'($urandom_range(PAGE_BYTES - 1));
          pick = $urandom_range(99);
          if (pick < 70) len = $urandom_range(4, 1);
          else if (pick < 92) len = $urandom_range(64, 5);
          else len = $urandom_range(span, 1);
          re = rs + ADDR_W'(len * PAGE_BYTES);
          if ($urandom_range(1)) re = re - ADDR_W'($urandom_range(PAGE_BYTES - 1));
          pick = $urandom_range(99);
          if (pick < 6) begin
            rs = rand48();
            re = rand48();
          end else if (pick < 10) begin
            re = rs;
          end else if (pick < 14) begin
            re = rs - ADDR_W'($urandom_range(8 * PAGE_BYTES, 1));
          end else if (pick < 20) begin
            rs = map_base - ADDR_W'($urandom_range(64 * PAGE_BYTES, 1));
          end
          send_request(REQ_RESERVE, rs, re);
        end
      end
      sent += block_len;
    end
    wait_drained();
  endtask

  // Result side: random back-pressure, compare each grant with the oldest owed one.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (grant_queue.size() == 0) begin
        note_mismatch($sformatf("unexpected grant addr=%h status=%0d", out_tdata, out_tuser));
      end else begin
        want = grant_queue.pop_front();
        if (out_tdata !== want.addr || out_tuser !== want.status)
          note_mismatch($sformatf("grant addr=%h status=%0d, expected addr=%h status=%0d",
                                  out_tdata, out_tuser, want.addr, want.status));
      end
    end
  end

  // Watchdog: count cycles in which no transaction completes on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // sender gaps 27 %, receiver stalls 59 %
    test_not_set_up();
    test_small_map();
    test_address_wrap();
    test_map_extremes();
    test_random_traffic(470);
    // swap the idling of the two sides
    sender_gap_pct = 59;
    sink_stall_pct = 27;
    test_random_traffic(470);
    // full rate on both sides
    sender_gap_pct = 0;
    sink_stall_pct = 0;
    test_random_traffic(460);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (grant_queue.size() != 0)
      note_mismatch($sformatf("%0d grants never arrived", grant_queue.size()));
    $display("Covered %0d allocations (%0d granted, %0d refused) and %0d reserves",
             alloc_granted + alloc_refused, alloc_granted, alloc_refused, reserves_sent);
    $display("under %0d register writes, across three idling patterns", reg_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
